>>> design/cbe_pkg.sv
package cbe_pkg;

  // Fixed-point format of the curve arithmetic
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int ACC_W     = 26;
  localparam int PROD_W    = ACC_W + T_W + 1;

  // Port widths
  localparam int PROG_W  = 18;
  localparam int EASED_W = 19;
  localparam int CX_W    = 17;
  localparam int CY_W    = 19;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 19;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_CTRL_X1 = 3'd0;
  localparam logic [CIDX_W-1:0] REG_CTRL_Y1 = 3'd1;
  localparam logic [CIDX_W-1:0] REG_CTRL_X2 = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CTRL_Y2 = 3'd3;

  localparam logic signed [ACC_W-1:0]   ONE_ACC   = ACC_W'(1 << FRAC_BITS);
  localparam logic signed [EASED_W-1:0] EASED_MAX = EASED_W'(262143);
  localparam logic signed [EASED_W-1:0] EASED_MIN = EASED_W'(-262144);

  // Horner coefficients of one curve coordinate
  typedef struct packed {
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] d;
    logic signed [ACC_W-1:0] e;
  } cbe_poly_t;

  // Coefficients of both coordinates, handed to the solver
  typedef struct packed {
    cbe_poly_t px;
    cbe_poly_t py;
  } cbe_coef_t;

  // c = 1 - 3b + 3a, d = 3b - 6a, e = 3a
  function automatic cbe_poly_t poly_coef(input logic signed [ACC_W-1:0] a,
                                          input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] a3;
    logic signed [ACC_W-1:0] b3;
    cbe_poly_t p;
    a3 = a + a + a;
    b3 = b + b + b;
    p.c = ONE_ACC - b3 + a3;
    p.d = b3 - a3 - a3;
    p.e = a3;
    return p;
  endfunction

endpackage

>>> design/cubic_bezier_easing_top.sv
// Channel   Handshake               Payload
// request   start / busy            in_progress
// result    out_valid (strobe)      out_eased
// config    cfg_valid / cfg_ready   cfg_index, cfg_wdata
//
// A progress value at or below zero or at or above one gives its result on the
// strobe in the cycle after acceptance, and busy stays low.
// Otherwise each bisection step runs on the one shared multiplier (midpoint,
// three Horner multiplies, compare), and the final y takes three more Horner
// multiplies. There are at most MAX_STEPS bisection steps. busy is high from
// acceptance up to the strobe cycle.
// Reset is synchronous; config writes are always taken (cfg_ready is high).
// The result is shown for one cycle only; the receiver cannot stall it.
module cubic_bezier_easing_top #(
  parameter int MAX_STEPS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [cbe_pkg::PROG_W-1:0]    in_progress,
  output logic                                 out_valid,
  output logic signed [cbe_pkg::EASED_W-1:0]   out_eased,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [cbe_pkg::CIDX_W-1:0]    cfg_index,
  input  logic        [cbe_pkg::CDATA_W-1:0]   cfg_wdata
);

  logic [cbe_pkg::CX_W-1:0] ctrl_x1_r, ctrl_x1_nxt;
  logic [cbe_pkg::CY_W-1:0] ctrl_y1_r, ctrl_y1_nxt;
  logic [cbe_pkg::CX_W-1:0] ctrl_x2_r, ctrl_x2_nxt;
  logic [cbe_pkg::CY_W-1:0] ctrl_y2_r, ctrl_y2_nxt;
  cbe_pkg::cbe_coef_t       coef_r, coef_nxt;

  assign cfg_ready = 1'b1;

  // Decode register writes; unknown indexes drop
  always_comb begin
    ctrl_x1_nxt = ctrl_x1_r;
    ctrl_y1_nxt = ctrl_y1_r;
    ctrl_x2_nxt = ctrl_x2_r;
    ctrl_y2_nxt = ctrl_y2_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        cbe_pkg::REG_CTRL_X1: ctrl_x1_nxt = cfg_wdata[cbe_pkg::CX_W-1:0];
        cbe_pkg::REG_CTRL_Y1: ctrl_y1_nxt = cfg_wdata[cbe_pkg::CY_W-1:0];
        cbe_pkg::REG_CTRL_X2: ctrl_x2_nxt = cfg_wdata[cbe_pkg::CX_W-1:0];
        cbe_pkg::REG_CTRL_Y2: ctrl_y2_nxt = cfg_wdata[cbe_pkg::CY_W-1:0];
        default: ;
      endcase
    end
  end

  // Derive Horner coefficients from the control points
  always_comb begin
    coef_nxt.px = cbe_pkg::poly_coef(
        $signed({{(cbe_pkg::ACC_W - cbe_pkg::CX_W){1'b0}}, ctrl_x1_r}),
        $signed({{(cbe_pkg::ACC_W - cbe_pkg::CX_W){1'b0}}, ctrl_x2_r}));
    coef_nxt.py = cbe_pkg::poly_coef(
        $signed({{(cbe_pkg::ACC_W - cbe_pkg::CY_W){ctrl_y1_r[cbe_pkg::CY_W-1]}}, ctrl_y1_r}),
        $signed({{(cbe_pkg::ACC_W - cbe_pkg::CY_W){ctrl_y2_r[cbe_pkg::CY_W-1]}}, ctrl_y2_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_x1_r <= '0;
      ctrl_y1_r <= '0;
      ctrl_x2_r <= cbe_pkg::CX_W'(1 << cbe_pkg::FRAC_BITS);
      ctrl_y2_r <= cbe_pkg::CY_W'(1 << cbe_pkg::FRAC_BITS);
    end else begin
      ctrl_x1_r <= ctrl_x1_nxt;
      ctrl_y1_r <= ctrl_y1_nxt;
      ctrl_x2_r <= ctrl_x2_nxt;
      ctrl_y2_r <= ctrl_y2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  cbe_seq #(
    .MAX_STEPS (MAX_STEPS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .progress  (in_progress),
    .coef      (coef_r),
    .out_valid (out_valid),
    .out_eased (out_eased)
  );

endmodule

>>> design/cbe_mac.sv
// One Horner step: floor(acc * t / 2^F) + addend
module cbe_mac (
  input  logic signed [cbe_pkg::ACC_W-1:0] acc,
  input  logic        [cbe_pkg::T_W-1:0]   t,
  input  logic signed [cbe_pkg::ACC_W-1:0] addend,
  output logic signed [cbe_pkg::ACC_W-1:0] res
);

  logic signed [cbe_pkg::PROD_W-1:0] prod;
  logic signed [cbe_pkg::PROD_W-1:0] scaled;

  // Arithmetic shift floors toward minus infinity
  assign prod   = acc * $signed({1'b0, t});
  assign scaled = prod >>> cbe_pkg::FRAC_BITS;
  assign res    = scaled[cbe_pkg::ACC_W-1:0] + addend;

endmodule

>>> design/cbe_seq.sv
// Bisection sequencer around the shared multiply-add unit
module cbe_seq #(
  parameter int MAX_STEPS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cbe_pkg::PROG_W-1:0]   progress,
  input  cbe_pkg::cbe_coef_t                  coef,
  output logic                                out_valid,
  output logic signed [cbe_pkg::EASED_W-1:0]  out_eased
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MID  = 4'b0010,
    S_MUL  = 4'b0100,
    S_CMP  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    PH_D    = 2'd0,
    PH_E    = 2'd1,
    PH_LAST = 2'd2
  } phase_t;

  state_t                              state_r, state_nxt;
  phase_t                              phase_r, phase_nxt;
  logic [STEP_W-1:0]                   step_r, step_nxt;
  logic                                sel_y_r, sel_y_nxt;
  logic [cbe_pkg::T_W-1:0]             lo_r, lo_nxt;
  logic [cbe_pkg::T_W-1:0]             hi_r, hi_nxt;
  logic [cbe_pkg::T_W-1:0]             t_r, t_nxt;
  logic signed [cbe_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [cbe_pkg::PROG_W-1:0]   x_r, x_nxt;
  logic                                valid_r, valid_nxt;
  logic signed [cbe_pkg::EASED_W-1:0]  eased_r, eased_nxt;

  cbe_pkg::cbe_poly_t                  poly;
  logic signed [cbe_pkg::ACC_W-1:0]    addend;
  logic signed [cbe_pkg::ACC_W-1:0]    mac_res;
  logic signed [cbe_pkg::ACC_W:0]      diff;
  logic [cbe_pkg::T_W:0]               mid_sum;
  logic                                accept;
  logic                                x_low;
  logic                                x_high;
  logic                                close;

  assign accept = start && (state_r == S_IDLE);
  assign x_low  = progress[cbe_pkg::PROG_W-1] || (progress == '0);
  assign x_high = progress >= $signed(cbe_pkg::PROG_W'(1 << cbe_pkg::FRAC_BITS));

  assign poly = sel_y_r ? coef.py : coef.px;

  // Pick the term added after this multiply
  always_comb begin
    unique case (phase_r)
      PH_D:    addend = poly.d;
      PH_E:    addend = poly.e;
      default: addend = '0;
    endcase
  end

  cbe_mac u_mac (
    .acc    (acc_r),
    .t      (t_r),
    .addend (addend),
    .res    (mac_res)
  );

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign diff    = {{(cbe_pkg::ACC_W + 1 - cbe_pkg::PROG_W){x_r[cbe_pkg::PROG_W-1]}}, x_r}
                   - {acc_r[cbe_pkg::ACC_W-1], acc_r};
  assign close   = (diff <= 1) && (diff >= -1);

  // Saturate the final y into the output range
  function automatic logic signed [cbe_pkg::EASED_W-1:0] sat(
      input logic signed [cbe_pkg::ACC_W-1:0] v);
    logic signed [cbe_pkg::EASED_W-1:0] s;
    if (v > $signed({{(cbe_pkg::ACC_W - cbe_pkg::EASED_W){1'b0}}, cbe_pkg::EASED_MAX})) begin
      s = cbe_pkg::EASED_MAX;
    end else if (v < $signed({{(cbe_pkg::ACC_W - cbe_pkg::EASED_W){1'b1}},
                              cbe_pkg::EASED_MIN})) begin
      s = cbe_pkg::EASED_MIN;
    end else begin
      s = v[cbe_pkg::EASED_W-1:0];
    end
    return s;
  endfunction

  // Sequence one request: clamp at the ends, else midpoint, three multiplies, compare, then y
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    sel_y_nxt = sel_y_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    t_nxt     = t_r;
    acc_nxt   = acc_r;
    x_nxt     = x_r;
    valid_nxt = 1'b0;
    eased_nxt = eased_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt = progress;
          if (x_low) begin
            valid_nxt = 1'b1;
            eased_nxt = '0;
          end else if (x_high) begin
            valid_nxt = 1'b1;
            eased_nxt = cbe_pkg::EASED_W'(1 << cbe_pkg::FRAC_BITS);
          end else begin
            lo_nxt    = '0;
            hi_nxt    = cbe_pkg::T_W'(1 << cbe_pkg::FRAC_BITS);
            step_nxt  = '0;
            sel_y_nxt = 1'b0;
            state_nxt = S_MID;
          end
        end
      end
      S_MID: begin
        t_nxt     = mid_sum[cbe_pkg::T_W:1];
        acc_nxt   = coef.px.c;
        phase_nxt = PH_D;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = mac_res;
        unique case (phase_r)
          PH_D:    phase_nxt = PH_E;
          PH_E:    phase_nxt = PH_LAST;
          default: begin
            if (sel_y_r) begin
              valid_nxt = 1'b1;
              eased_nxt = sat(mac_res);
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_CMP;
            end
          end
        endcase
      end
      S_CMP: begin
        if (close || (step_r == LAST_STEP)) begin
          sel_y_nxt = 1'b1;
          acc_nxt   = coef.py.c;
          phase_nxt = PH_D;
          state_nxt = S_MUL;
        end else begin
          if (diff > 0) begin
            lo_nxt = t_r;
          end else begin
            hi_nxt = t_r;
          end
          step_nxt  = step_r + 1'b1;
          state_nxt = S_MID;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control under reset, advance otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_D;
      step_r  <= '0;
      sel_y_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      sel_y_r <= sel_y_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    t_r     <= t_nxt;
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    eased_r <= eased_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_eased = eased_r;

endmodule

>>> design/cbe_checker.sv
module cbe_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic signed [cbe_pkg::PROG_W-1:0]   in_progress,
  input logic                                out_valid,
  input logic signed [cbe_pkg::EASED_W-1:0]  out_eased,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  localparam logic signed [cbe_pkg::PROG_W-1:0] ONE_X =
    cbe_pkg::PROG_W'(1 << cbe_pkg::FRAC_BITS);
  localparam logic signed [cbe_pkg::EASED_W-1:0] ONE_Y =
    cbe_pkg::EASED_W'(1 << cbe_pkg::FRAC_BITS);

  // A request at or below zero answers zero on the next cycle
  a_low_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_progress <= 0) |=> (out_valid && out_eased == 0 && !busy))
    else $error("low clamp result missing");

  // A request at or above one answers one on the next cycle
  a_high_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_progress >= ONE_X) |=> (out_valid && out_eased == ONE_Y && !busy))
    else $error("high clamp result missing");

  // An interior request starts the solver with no immediate result
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_progress > 0 && in_progress < ONE_X) |=> (busy && !out_valid))
    else $error("solver did not start");

  // A result never shows while the solver still runs
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // The register port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind cubic_bezier_easing_top cbe_checker u_cbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_progress (in_progress),
  .out_valid   (out_valid),
  .out_eased   (out_eased),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);

>>> tb/sv/testbench.sv
module testbench;

  localparam int STEPS       = 24;
  localparam int SLOWEST     = 5 * STEPS + 4;
  localparam int STALL_LIMIT = 16 * SLOWEST;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int UNIT        = 1 << cbe_pkg::FRAC_BITS;
  localparam int FIRST_UNUSED_REG = int'(cbe_pkg::REG_CTRL_Y2) + 1;
  localparam int LAST_REG_SLOT    = (1 << cbe_pkg::CIDX_W) - 1;

  localparam logic [cbe_pkg::CY_W-1:0] CY_MAX = {1'b0, {(cbe_pkg::CY_W-1){1'b1}}};
  localparam logic [cbe_pkg::CY_W-1:0] CY_MIN = {1'b1, {(cbe_pkg::CY_W-1){1'b0}}};
  localparam logic signed [cbe_pkg::EASED_W-1:0] EASED_ONE = cbe_pkg::EASED_W'(UNIT);
  localparam logic signed [cbe_pkg::EASED_W-1:0] EASED_0   = '0;

  // One corner request and, where obvious, its eased value
  typedef struct packed {
    logic signed [cbe_pkg::PROG_W-1:0]  progress;
    logic                               known;
    logic signed [cbe_pkg::EASED_W-1:0] eased;
  } corner_row_t;

  typedef struct packed {
    logic signed [cbe_pkg::PROG_W-1:0]  progress;
    logic signed [cbe_pkg::EASED_W-1:0] eased;
  } eased_req_t;

  // Progress corners under the reset curve
  localparam corner_row_t CORNER_ROWS [12] = '{
    '{cbe_pkg::PROG_W'(-131072), 1'b1, EASED_0},
    '{cbe_pkg::PROG_W'(-1),      1'b1, EASED_0},
    '{cbe_pkg::PROG_W'(0),       1'b1, EASED_0},
    '{cbe_pkg::PROG_W'(1),       1'b0, EASED_0},
    '{cbe_pkg::PROG_W'(2),       1'b0, EASED_0},
    '{cbe_pkg::PROG_W'(16384),   1'b0, EASED_0},
    '{cbe_pkg::PROG_W'(32768),   1'b0, EASED_0},
    '{cbe_pkg::PROG_W'(49152),   1'b0, EASED_0},
    '{cbe_pkg::PROG_W'(65535),   1'b0, EASED_0},
    '{cbe_pkg::PROG_W'(65536),   1'b1, EASED_ONE},
    '{cbe_pkg::PROG_W'(65537),   1'b1, EASED_ONE},
    '{cbe_pkg::PROG_W'(131071),  1'b1, EASED_ONE}
  };

  // Extreme control points: x1, y1, x2, y2
  localparam logic [cbe_pkg::CDATA_W-1:0] EXTREME_CURVES [3][4] = '{
    '{cbe_pkg::CDATA_W'(UNIT), CY_MAX, cbe_pkg::CDATA_W'(0), CY_MIN},
    // x written with all bits set: bits above the register are dropped
    '{cbe_pkg::CDATA_W'(19'h7FFFF), CY_MIN, cbe_pkg::CDATA_W'(19'h7FFFF), CY_MAX},
    '{cbe_pkg::CDATA_W'(0), cbe_pkg::CDATA_W'(0), cbe_pkg::CDATA_W'(0),
      cbe_pkg::CDATA_W'(0)}
  };
  localparam logic signed [cbe_pkg::PROG_W-1:0] MID_POINTS [3] = '{
    cbe_pkg::PROG_W'(1), cbe_pkg::PROG_W'(32768), cbe_pkg::PROG_W'(65535)
  };

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic signed [cbe_pkg::PROG_W-1:0]   in_progress;
  logic                                out_valid;
  logic signed [cbe_pkg::EASED_W-1:0]  out_eased;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic        [cbe_pkg::CIDX_W-1:0]   cfg_index;
  logic        [cbe_pkg::CDATA_W-1:0]  cfg_wdata;

  // Curve registers as the block should hold them
  logic        [cbe_pkg::CX_W-1:0] cur_x1;
  logic signed [cbe_pkg::CY_W-1:0] cur_y1;
  logic        [cbe_pkg::CX_W-1:0] cur_x2;
  logic signed [cbe_pkg::CY_W-1:0] cur_y2;

  eased_req_t pending_eased[$];
  eased_req_t head;
  int         errors = 0;
  int         stall_cycles = 0;

  always #4 clk = ~clk;

  cubic_bezier_easing_top #(.MAX_STEPS(STEPS)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_progress (in_progress),
    .out_valid   (out_valid),
    .out_eased   (out_eased),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  // Horner evaluation of one curve coordinate, each product floored
  function automatic longint bezier_coord(input longint t, input longint a, input longint b);
    longint c, d, e, acc;
    c = longint'(UNIT) - 3 * b + 3 * a;
    d = 3 * b - 6 * a;
    e = 3 * a;
    acc = ((c * t) >>> cbe_pkg::FRAC_BITS) + d;
    acc = ((acc * t) >>> cbe_pkg::FRAC_BITS) + e;
    return (acc * t) >>> cbe_pkg::FRAC_BITS;
  endfunction

  // Clamp, bisect t until curve x is within one LSB, then evaluate y
  function automatic logic signed [cbe_pkg::EASED_W-1:0] solve_eased(
      input logic signed [cbe_pkg::PROG_W-1:0] p);
    longint x, lo, hi, t, est, y;
    bit     settled;
    x = p;
    if (x <= 0) begin
      y = 0;
    end else if (x >= UNIT) begin
      y = UNIT;
    end else begin
      lo = 0;
      hi = UNIT;
      t = x;
      settled = 1'b0;
      for (int i = 0; i < STEPS && !settled; i++) begin
        t = (lo + hi) / 2;
        est = bezier_coord(t, cur_x1, cur_x2);
        if (x - est <= 1 && x - est >= -1) settled = 1'b1;
        else if (est < x) lo = t;
        else hi = t;
      end
      y = bezier_coord(t, cur_y1, cur_y2);
    end
    if (y > cbe_pkg::EASED_MAX) y = cbe_pkg::EASED_MAX;
    if (y < cbe_pkg::EASED_MIN) y = cbe_pkg::EASED_MIN;
    return y[cbe_pkg::EASED_W-1:0];
  endfunction

  // Mostly inside the open interval, some edges, some anything
  function automatic logic signed [cbe_pkg::PROG_W-1:0] pick_progress();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return cbe_pkg::PROG_W'($urandom_range(1, UNIT - 1));
    if (r < 75) begin
      case ($urandom_range(0, 7))
        0: return cbe_pkg::PROG_W'(0);
        1: return cbe_pkg::PROG_W'(1);
        2: return cbe_pkg::PROG_W'(2);
        3: return cbe_pkg::PROG_W'(UNIT - 2);
        4: return cbe_pkg::PROG_W'(UNIT - 1);
        5: return cbe_pkg::PROG_W'(UNIT);
        6: return cbe_pkg::PROG_W'(UNIT + 1);
        default: return cbe_pkg::PROG_W'(-1);
      endcase
    end
    return cbe_pkg::PROG_W'($urandom);
  endfunction

  // Control x: mostly within zero to one, sometimes past one
  function automatic logic [cbe_pkg::CDATA_W-1:0] pick_ctrl_x();
    logic [cbe_pkg::CDATA_W-1:0] v;
    v = cbe_pkg::CDATA_W'($urandom);
    case ($urandom_range(0, 9))
      0: v[cbe_pkg::CX_W-1:0] = '0;
      1: v[cbe_pkg::CX_W-1:0] = cbe_pkg::CX_W'(UNIT);
      2, 3: ;
      default: v[cbe_pkg::CX_W-1:0] = cbe_pkg::CX_W'($urandom_range(0, UNIT));
    endcase
    return v;
  endfunction

  // Control y: mostly -1 .. 2, sometimes the range ends or anything
  function automatic logic [cbe_pkg::CDATA_W-1:0] pick_ctrl_y();
    case ($urandom_range(0, 9))
      0: return CY_MAX;
      1: return CY_MIN;
      2, 3: return cbe_pkg::CDATA_W'($urandom);
      default: return cbe_pkg::CDATA_W'(int'($urandom_range(0, 3 * UNIT)) - UNIT);
    endcase
  endfunction

  // Write one register; cfg_valid stays high for a following write
  task automatic write_reg(input logic [cbe_pkg::CIDX_W-1:0] idx,
                           input logic [cbe_pkg::CDATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      cbe_pkg::REG_CTRL_X1: cur_x1 = val[cbe_pkg::CX_W-1:0];
      cbe_pkg::REG_CTRL_Y1: cur_y1 = val[cbe_pkg::CY_W-1:0];
      cbe_pkg::REG_CTRL_X2: cur_x2 = val[cbe_pkg::CX_W-1:0];
      cbe_pkg::REG_CTRL_Y2: cur_y2 = val[cbe_pkg::CY_W-1:0];
      default: ;
    endcase
  endtask

  // Load a curve, then poke an unused slot that must be ignored
  task automatic set_curve(input logic [cbe_pkg::CDATA_W-1:0] x1,
                           input logic [cbe_pkg::CDATA_W-1:0] y1,
                           input logic [cbe_pkg::CDATA_W-1:0] x2,
                           input logic [cbe_pkg::CDATA_W-1:0] y2);
    write_reg(cbe_pkg::REG_CTRL_X1, x1);
    write_reg(cbe_pkg::REG_CTRL_Y1, y1);
    write_reg(cbe_pkg::REG_CTRL_X2, x2);
    write_reg(cbe_pkg::REG_CTRL_Y2, y2);
    write_reg(cbe_pkg::CIDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_SLOT)),
              cbe_pkg::CDATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request; start stays high on return
  task automatic send_progress(input logic signed [cbe_pkg::PROG_W-1:0] p,
                               input logic known,
                               input logic signed [cbe_pkg::EASED_W-1:0] want);
    eased_req_t req;
    start <= 1'b1;
    in_progress <= p;
    do @(posedge clk); while (busy !== 1'b0);
    req.progress = p;
    req.eased = known ? want : solve_eased(p);
    pending_eased.push_back(req);
  endtask

  // Stop offering and wait until the block has answered everything
  task automatic drain();
    start <= 1'b0;
    while (pending_eased.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int idle_pct;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_progress <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    cur_x1 = '0;
    cur_y1 = '0;
    cur_x2 = cbe_pkg::CX_W'(UNIT);
    cur_y2 = cbe_pkg::CY_W'(UNIT);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Corners under the reset curve
    foreach (CORNER_ROWS[i])
      send_progress(CORNER_ROWS[i].progress, CORNER_ROWS[i].known, CORNER_ROWS[i].eased);

    // Extreme control points
    foreach (EXTREME_CURVES[k]) begin
      drain();
      set_curve(EXTREME_CURVES[k][0], EXTREME_CURVES[k][1],
                EXTREME_CURVES[k][2], EXTREME_CURVES[k][3]);
      foreach (MID_POINTS[m]) send_progress(MID_POINTS[m], 1'b0, EASED_0);
    end

    // Random curves and progress values; no idling in the last phase
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      set_curve(pick_ctrl_x(), pick_ctrl_y(), pick_ctrl_x(), pick_ctrl_y());
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (phase == PHASES - 1) idle_pct = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_progress(pick_progress(), 1'b0, EASED_0);
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          in_progress <= cbe_pkg::PROG_W'($urandom);
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end

    // Wait out the last results, then a full solve time more
    start <= 1'b0;
    while (pending_eased.size() != 0) @(posedge clk);
    repeat (SLOWEST + 6) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Compare each strobed result with the oldest request
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_eased.size() == 0) begin
        $display("%0t: eased %0d with no request waiting", $time, out_eased);
        errors++;
      end else begin
        head = pending_eased.pop_front();
        if (out_eased !== head.eased) begin
          $display("%0t: eased for progress %0d: expected %0d, actual %0d",
                   $time, head.progress, head.eased, out_eased);
          errors++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
